>>> rtl/tilt_lowpass_radial_deadzone_assert.svh
// assertion macros shared by the checker
`ifndef TILT_LOWPASS_RADIAL_DEADZONE_ASSERT_SVH
`define TILT_LOWPASS_RADIAL_DEADZONE_ASSERT_SVH

// same-cycle implication, held off while in reset
`define TLRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define TLRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tlrd_pkg.sv
`timescale 1ns / 1ps

package tlrd_pkg;

    localparam int IN_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ALPHA_W  = 16;
    localparam int DZ_W     = 15;
    localparam int CNT_W    = 5;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_Y    = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13107;
    localparam logic [DZ_W-1:0]    DZ_RESET    = 15'd205;

    typedef struct packed {
        logic load_in;
        logic diff;
        logic mul;
        logic upd;
        logic map;
        logic sq;
        logic sum;
        logic sqrt_step;
        logic keep;
        logic num;
        logic div_init;
        logic div_step;
        logic out_load;
    } tlrd_cmd_t;

    typedef struct packed {
        logic zero;
        logic out_free;
    } tlrd_sts_t;

endpackage

>>> rtl/tlrd_ctrl.sv
`timescale 1ns / 1ps

module tlrd_ctrl import tlrd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tlrd_sts_t sts,
    output tlrd_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_UPD   = 4'd3;
    localparam logic [3:0] ST_MAP   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_KEEP  = 4'd8;
    localparam logic [3:0] ST_NUM   = 4'd9;
    localparam logic [3:0] ST_DINIT = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_MAP;
            end
            ST_MAP: begin
                cmd.map    = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sts.zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.sqrt_step = 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                        cnt_next   = '0;
                        state_next = ST_KEEP;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_KEEP: begin
                cmd.keep   = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.num    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/tlrd_dp.sv
`timescale 1ns / 1ps

module tlrd_dp import tlrd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tlrd_cmd_t               cmd,
    output tlrd_sts_t               sts,
    input  logic signed [IN_W-1:0]  s_accel_x,
    input  logic signed [IN_W-1:0]  s_accel_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [IN_W-1:0]  m_tilt_x,
    output logic signed [IN_W-1:0]  m_tilt_y,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    // configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [DZ_W-1:0]    dz_reg;
    logic               swap_reg, negx_reg, negy_reg;

    // filter state
    logic signed [31:0] filt_x_reg, filt_y_reg;
    logic               primed_reg;

    logic signed [15:0] ax_reg, ay_reg;
    logic signed [33:0] diff_x_reg, diff_y_reg;
    logic signed [50:0] prod_x_reg, prod_y_reg;
    logic signed [16:0] tx_reg, ty_reg;
    logic [30:0]        sqx_reg, sqy_reg;
    logic [29:0]        dz2_reg;
    logic               zero_reg;
    logic [47:0]        rad_reg;
    logic [26:0]        srem_reg;
    logic [23:0]        root_reg;
    logic [23:0]        keep_reg;
    logic [16:0]        magx_reg, magy_reg;
    logic [40:0]        numx_reg, numy_reg;
    logic [24:0]        remx_reg, remy_reg;
    logic [16:0]        dqx_reg, dqy_reg;
    logic               m_valid_reg;
    logic signed [15:0] tilt_x_reg, tilt_y_reg;

    logic signed [33:0] tgt_x, tgt_y, fext_x, fext_y;
    logic signed [31:0] rnd_x, rnd_y;
    logic signed [15:0] fx16, fy16, selx, sely;
    logic signed [16:0] selx17, sely17;
    logic signed [33:0] sqx_full, sqy_full;
    logic [31:0]        sq_sum;
    logic [26:0]        srem_sh, strial;
    logic               sge;
    logic [24:0]        divisor;
    logic [41:0]        dvdx, dvdy;
    logic [25:0]        rshx, rshy;
    logic               gex, gey;
    logic [16:0]        negqx, negqy;
    logic signed [15:0] outx, outy;

    assign tgt_x  = {{2{ax_reg[15]}}, ax_reg, 16'b0};
    assign tgt_y  = {{2{ay_reg[15]}}, ay_reg, 16'b0};
    assign fext_x = {{2{filt_x_reg[31]}}, filt_x_reg};
    assign fext_y = {{2{filt_y_reg[31]}}, filt_y_reg};

    // round filter state to q3.12, then swap and negate
    assign rnd_x  = filt_x_reg + 32'sd32768;
    assign rnd_y  = filt_y_reg + 32'sd32768;
    assign fx16   = rnd_x[31:16];
    assign fy16   = rnd_y[31:16];
    assign selx   = swap_reg ? fy16 : fx16;
    assign sely   = swap_reg ? fx16 : fy16;
    assign selx17 = {selx[15], selx};
    assign sely17 = {sely[15], sely};

    assign sqx_full = 34'(tx_reg) * 34'(tx_reg);
    assign sqy_full = 34'(ty_reg) * 34'(ty_reg);
    assign sq_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // one root bit per step
    assign srem_sh = {srem_reg[24:0], rad_reg[47:46]};
    assign strial  = {1'b0, root_reg, 2'b01};
    assign sge     = (srem_sh >= strial);

    // rounded quotient of (2*num + m) / (2*m), one bit per step on each axis
    assign divisor = {root_reg, 1'b0};
    assign dvdx    = {numx_reg, 1'b0} + {18'b0, root_reg};
    assign dvdy    = {numy_reg, 1'b0} + {18'b0, root_reg};
    assign rshx    = {remx_reg, dqx_reg[16]};
    assign rshy    = {remy_reg, dqy_reg[16]};
    assign gex     = (rshx >= {1'b0, divisor});
    assign gey     = (rshy >= {1'b0, divisor});

    assign negqx = ~dqx_reg + 17'd1;
    assign negqy = ~dqy_reg + 17'd1;

    always_comb begin
        if (zero_reg) begin
            outx = '0;
        end else if (tx_reg[16]) begin
            outx = negqx[15:0];
        end else if (dqx_reg[16] || dqx_reg[15]) begin
            outx = 16'sh7fff;
        end else begin
            outx = dqx_reg[15:0];
        end
        if (zero_reg) begin
            outy = '0;
        end else if (ty_reg[16]) begin
            outy = negqy[15:0];
        end else if (dqy_reg[16] || dqy_reg[15]) begin
            outy = 16'sh7fff;
        end else begin
            outy = dqy_reg[15:0];
        end
    end

    assign sts.zero     = zero_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_tilt_x = tilt_x_reg;
    assign m_tilt_y = tilt_y_reg;

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= ALPHA_RESET;
            dz_reg      <= DZ_RESET;
            swap_reg    <= 1'b0;
            negx_reg    <= 1'b0;
            negy_reg    <= 1'b0;
            filt_x_reg  <= '0;
            filt_y_reg  <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ALPHA:    alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    CFG_DEADZONE: dz_reg    <= cfg_wdata[DZ_W-1:0];
                    CFG_SWAP:     swap_reg  <= cfg_wdata[0];
                    CFG_NEG_X:    negx_reg  <= cfg_wdata[0];
                    CFG_NEG_Y:    negy_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.upd) begin
                // first word after reset seeds the filter
                if (!primed_reg) begin
                    filt_x_reg <= {ax_reg, 16'b0};
                    filt_y_reg <= {ay_reg, 16'b0};
                end else begin
                    filt_x_reg <= filt_x_reg + prod_x_reg[47:16];
                    filt_y_reg <= filt_y_reg + prod_y_reg[47:16];
                end
                primed_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ax_reg <= s_accel_x;
            ay_reg <= s_accel_y;
        end
        if (cmd.diff) begin
            diff_x_reg <= tgt_x - fext_x;
            diff_y_reg <= tgt_y - fext_y;
        end
        if (cmd.mul) begin
            prod_x_reg <= 51'(diff_x_reg) * $signed({35'b0, alpha_reg});
            prod_y_reg <= 51'(diff_y_reg) * $signed({35'b0, alpha_reg});
        end
        if (cmd.map) begin
            tx_reg <= negx_reg ? -selx17 : selx17;
            ty_reg <= negy_reg ? -sely17 : sely17;
        end
        if (cmd.sq) begin
            sqx_reg <= sqx_full[30:0];
            sqy_reg <= sqy_full[30:0];
            dz2_reg <= {15'b0, dz_reg} * {15'b0, dz_reg};
        end
        if (cmd.sum) begin
            zero_reg <= (sq_sum < {2'b0, dz2_reg}) || (sq_sum == '0);
            rad_reg  <= {sq_sum, 16'b0};
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            srem_reg <= sge ? (srem_sh - strial) : srem_sh;
            root_reg <= {root_reg[22:0], sge};
            rad_reg  <= {rad_reg[45:0], 2'b00};
        end
        if (cmd.keep) begin
            keep_reg <= root_reg - {1'b0, dz_reg, 8'b0};
            magx_reg <= tx_reg[16] ? (~tx_reg + 17'd1) : tx_reg;
            magy_reg <= ty_reg[16] ? (~ty_reg + 17'd1) : ty_reg;
        end
        if (cmd.num) begin
            numx_reg <= {24'b0, magx_reg} * {17'b0, keep_reg};
            numy_reg <= {24'b0, magy_reg} * {17'b0, keep_reg};
        end
        if (cmd.div_init) begin
            remx_reg <= dvdx[41:17];
            dqx_reg  <= dvdx[16:0];
            remy_reg <= dvdy[41:17];
            dqy_reg  <= dvdy[16:0];
        end
        if (cmd.div_step) begin
            remx_reg <= gex ? 25'(rshx - {1'b0, divisor}) : rshx[24:0];
            dqx_reg  <= {dqx_reg[15:0], gex};
            remy_reg <= gey ? 25'(rshy - {1'b0, divisor}) : rshy[24:0];
            dqy_reg  <= {dqy_reg[15:0], gey};
        end
        if (cmd.out_load) begin
            tilt_x_reg <= outx;
            tilt_y_reg <= outy;
        end
    end

endmodule

>>> rtl/tilt_lowpass_radial_deadzone.sv
`timescale 1ns / 1ps
// Tilt low-pass filter with radial subtractive deadzone.
// Input channel s_valid/s_ready carries one accelerometer word (s_accel_x, s_accel_y,
// signed q3.12 g). Output channel m_valid/m_ready carries one word per input
// (m_tilt_x, m_tilt_y, signed q3.12 g).
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata, one per cycle; the user
// must write them only while idle, the block does not enforce it. Register indices:
// 0 smoothing alpha, 1 deadzone radius, 2 swap axes, 3 negate x, 4 negate y.
// Each word runs the 24-step square root and the 17-step divider, both axes in parallel;
// a vector inside the deadzone skips both. The block works on one word at a time.
// The output register decouples the channels: a new word is taken while a result
// still waits. If the receiver stalls, the finished result holds in the output
// register and the next word stops at its last step until the register frees.
// Reset loads register defaults, clears the filter and makes the next word seed it.
module tilt_lowpass_radial_deadzone import tlrd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [IN_W-1:0] s_accel_x,
    input  logic signed [IN_W-1:0] s_accel_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [IN_W-1:0] m_tilt_x,
    output logic signed [IN_W-1:0] m_tilt_y,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    tlrd_cmd_t cmd;
    tlrd_sts_t sts;

    tlrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tlrd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_accel_x (s_accel_x),
        .s_accel_y (s_accel_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tilt_x  (m_tilt_x),
        .m_tilt_y  (m_tilt_y),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> rtl/tlrd_checker.sv
`timescale 1ns / 1ps
`include "tilt_lowpass_radial_deadzone_assert.svh"

module tlrd_checker import tlrd_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic signed [IN_W-1:0] m_tilt_x,
    input logic signed [IN_W-1:0] m_tilt_y
);

    `TLRD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_tilt_x) && $stable(m_tilt_y), "stalled output word changed")

    `TLRD_ASSERT_IMP(a_out_drop, aclk, aresetn, $fell(m_valid),
        $past(m_ready), "output word dropped without handshake")

    `TLRD_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready,
        !s_ready, "second word taken while one is in work")

    `TLRD_ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready,
        !$rose(m_valid), "result appeared right after input accept")

endmodule

bind tilt_lowpass_radial_deadzone tlrd_checker u_tlrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_tilt_x (m_tilt_x),
    .m_tilt_y (m_tilt_y)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlrd_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
    } tilt_word_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    class tilt_tracker;
        logic [ALPHA_W-1:0] alpha = ALPHA_RESET;
        logic [DZ_W-1:0] radius = DZ_RESET;
        bit swap_xy = 1'b0;
        bit flip_x = 1'b0;
        bit flip_y = 1'b0;
        logic signed [31:0] acc_x = '0;
        logic signed [31:0] acc_y = '0;
        bit seeded = 1'b0;
        tilt_word_t want[$];
        int errors = 0;
        int samples = 0;
        int words = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALPHA: alpha = data[ALPHA_W-1:0];
                CFG_DEADZONE: radius = data[DZ_W-1:0];
                CFG_SWAP: swap_xy = data[0];
                CFG_NEG_X: flip_x = data[0];
                CFG_NEG_Y: flip_y = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return want.size();
        endfunction

        function logic signed [31:0] smooth(logic signed [31:0] acc,
                                            logic signed [IN_W-1:0] raw);
            longint delta;
            delta = (longint'(raw) <<< 16) - longint'(acc);
            delta = (delta * longint'(alpha)) >>> 16;
            return 32'(longint'(acc) + delta);
        endfunction

        function int to_q12(logic signed [31:0] acc);
            return int'((longint'(acc) + 32768) >>> 16);
        endfunction

        function u64_t floor_root(u64_t v);
            u64_t res = 0;
            u64_t probe = u64_t'(1) << 62;
            while (probe > v)
                probe >>= 2;
            while (probe != 0) begin
                if (v >= res + probe) begin
                    v -= res + probe;
                    res = (res >> 1) + probe;
                end else begin
                    res >>= 1;
                end
                probe >>= 2;
            end
            return res;
        endfunction

        function logic signed [IN_W-1:0] shrink(longint t, u64_t keep, u64_t m);
            u64_t mag;
            longint q;
            mag = (t < 0) ? u64_t'(-t) : u64_t'(t);
            q = longint'((2 * mag * keep + m) / (2 * m));
            if (t < 0)
                q = -q;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[IN_W-1:0];
        endfunction

        function void accept_sample(logic signed [IN_W-1:0] ax, logic signed [IN_W-1:0] ay);
            int fx, fy;
            longint tx, ty;
            u64_t sq, dzsq, m, keep;
            tilt_word_t w;
            if (!seeded) begin
                acc_x = {ax, 16'h0000};
                acc_y = {ay, 16'h0000};
                seeded = 1'b1;
            end
            acc_x = smooth(acc_x, ax);
            acc_y = smooth(acc_y, ay);
            fx = to_q12(acc_x);
            fy = to_q12(acc_y);
            tx = swap_xy ? fy : fx;
            ty = swap_xy ? fx : fy;
            if (flip_x)
                tx = -tx;
            if (flip_y)
                ty = -ty;
            sq = u64_t'(tx * tx + ty * ty);
            dzsq = u64_t'(radius) * u64_t'(radius);
            if (sq < dzsq || sq == 0) begin
                w.x = '0;
                w.y = '0;
            end else begin
                m = floor_root(sq << 16);
                keep = m - u64_t'(radius) * 256;
                w.x = shrink(tx, keep, m);
                w.y = shrink(ty, keep, m);
            end
            want.push_back(w);
            samples++;
        endfunction

        function void check_tilt(logic signed [IN_W-1:0] gx, logic signed [IN_W-1:0] gy);
            tilt_word_t w;
            if (want.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected tilt word x=%0d y=%0d", gx, gy);
                return;
            end
            w = want.pop_front();
            words++;
            if (gx !== w.x || gy !== w.y) begin
                errors++;
                if (errors <= 10)
                    $display("tilt word %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                             words, w.x, w.y, gx, gy);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_accel_x = '0;
    logic signed [IN_W-1:0] s_accel_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [IN_W-1:0] m_tilt_x;
    logic signed [IN_W-1:0] m_tilt_y;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    tilt_tracker tracker = new;
    int cycles = 0;
    int burst_left = 0;
    int settings = 0;
    int center_x = 0;
    int center_y = 0;
    logic signed [IN_W-1:0] last_x = '0;
    logic signed [IN_W-1:0] last_y = '0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_hold = 0;

    tilt_lowpass_radial_deadzone uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_accel_x (s_accel_x),
        .s_accel_y (s_accel_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tilt_x  (m_tilt_x),
        .m_tilt_y  (m_tilt_y),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(50, 600);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (cycles % 13) < 5;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_tilt(m_tilt_x, m_tilt_y);
    end

    function automatic logic signed [IN_W-1:0] clamp16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[IN_W-1:0];
    endfunction

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic send_sample(input logic signed [IN_W-1:0] x,
                               input logic signed [IN_W-1:0] y);
        s_valid <= 1'b1;
        s_accel_x <= x;
        s_accel_y <= y;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.accept_sample(x, y);
        last_x = x;
        last_y = y;
        // bursts with random gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 90))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        tracker.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [ALPHA_W-1:0] alpha, input logic [DZ_W-1:0] dz,
                                  input bit swap_xy, input bit flip_x, input bit flip_y);
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_DEADZONE, {1'($urandom), dz});
        if ($urandom_range(0, 1))
            write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
        write_reg(CFG_SWAP, {15'($urandom), swap_xy});
        write_reg(CFG_NEG_X, {15'($urandom), flip_x});
        write_reg(CFG_NEG_Y, {15'($urandom), flip_y});
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    task automatic feed_random(input int count);
        logic signed [IN_W-1:0] x, y;
        int span;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    center_x = clamp16(center_x + $urandom_range(0, 2000) - 1000);
                    center_y = clamp16(center_y + $urandom_range(0, 2000) - 1000);
                    x = clamp16(center_x + $urandom_range(0, 400) - 200);
                    y = clamp16(center_y + $urandom_range(0, 400) - 200);
                end
                4, 5: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                6: begin
                    x = pick_extreme();
                    y = pick_extreme();
                end
                7, 8: begin
                    span = int'(tracker.radius) + 64;
                    x = clamp16(int'($urandom_range(0, 2 * span)) - span);
                    y = clamp16(int'($urandom_range(0, 2 * span)) - span);
                end
                default: begin
                    x = last_x;
                    y = last_y;
                end
            endcase
            send_sample(x, y);
        end
    endtask

    function automatic logic [DZ_W-1:0] pick_radius();
        case ($urandom_range(0, 5))
            0: return '0;
            1, 2: return DZ_W'($urandom_range(0, 1023));
            3, 4: return DZ_W'($urandom_range(0, 8191));
            default: return DZ_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(0, 4))
            0: return 16'hFFFF;
            1: return ALPHA_W'($urandom_range(1, 4095));
            2: return ALPHA_RESET;
            default: return ALPHA_W'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        repeat (12)
            @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults, first word seeds the filter
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd150, -16'sd100);

        // full tracking, no deadzone, negation of the most negative value
        apply_settings(16'hFFFF, 15'd0, 1'b1, 1'b1, 1'b1);
        repeat (3)
            send_sample(-16'sd32768, -16'sd32768);
        repeat (2)
            send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, -16'sd1);
        send_sample(-16'sd1, 16'sd1);

        // frozen filter, widest deadzone
        apply_settings(16'h0000, 15'h7FFF, 1'b0, 1'b0, 1'b1);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(16'sd1, -16'sd1);

        apply_settings(16'h0001, 15'd1, 1'b1, 1'b0, 1'b0);
        send_sample(16'sd12345, -16'sd23456);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);

        apply_settings(16'h8000, 15'd4096, 1'b0, 1'b1, 1'b0);
        send_sample(16'sd4096, 16'sd0);
        send_sample(16'sd0, 16'sd4096);
        send_sample(16'sd2896, 16'sd2896);
        send_sample(-16'sd5000, 16'sd3000);

        for (int p = 0; p < 6; p++) begin
            apply_settings(pick_alpha(), pick_radius(), 1'($urandom), 1'($urandom),
                           1'($urandom));
            feed_random(125);
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);

        $display("%0d samples sent, %0d tilt words checked under %0d register settings",
                 tracker.samples, tracker.words, settings);
        $display("%0d errors, %0d words still outstanding", tracker.errors, tracker.pending());
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> tilt_lowpass_radial_deadzone.f
+incdir+rtl
rtl/tlrd_pkg.sv
rtl/tlrd_ctrl.sv
rtl/tlrd_dp.sv
rtl/tilt_lowpass_radial_deadzone.sv
rtl/tlrd_checker.sv
verif/tb.sv
